[sv/hrit_pkg.sv]
// Shared constants, types and helper functions for the twisted-ribbon inside test.
// Used by the channel interfaces, the CORDIC, square-root and reducer pipes, and the core.
// No dependencies.
package hrit_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 32;
  localparam int MOD_STEPS    = 30;

  // Datapath widths
  localparam int COORD_W = 32;   // Q16.16 coordinates
  localparam int ANG_W   = 35;   // signed Q30 angles, range just under +-16 rad
  localparam int VEC_W   = 60;   // vectoring CORDIC x/y (operands scaled by 2^24)
  localparam int ROT_W   = 34;   // rotation CORDIC x/y
  localparam int VEC_PRESCALE = 24;

  // Angles, Q30 radians
  localparam logic signed [ANG_W-1:0] PI_Q30          = 35'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30     = 35'sd1686629713;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30      = 35'sd6746518852;
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN_Q30 = 35'sd652032874;

  // Bend radius and wobble period are powers of two: 2^21 and 2^20 in Q16.16
  localparam int BEND_LOG2   = 21;
  localparam int WOBBLE_LOG2 = 20;
  localparam logic signed [ANG_W-1:0] BEND_RADIUS = 35'sd1 <<< BEND_LOG2;
  // arc_len = ((arc >>> 2) * bend) >>> 28 collapses to one shift
  localparam int ARC_SHIFT = 2 + 28 - BEND_LOG2;

  // Bias that lifts the twist product to a non-negative value with the same residue
  localparam logic [63:0] MOD_BIAS = 64'(TWO_PI_Q30) << (MOD_STEPS - 1);

  localparam logic [31:0] ATAN_TABLE [CORDIC_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
  };

  // Configuration register indexes
  typedef enum logic [3:0] {
    REG_CENTER_X         = 4'd0,
    REG_CENTER_Y         = 4'd1,
    REG_CENTER_Z         = 4'd2,
    REG_TWIST_RATE       = 4'd3,
    REG_TUBE_RADIUS      = 4'd4,
    REG_RIBBON_THICKNESS = 4'd5,
    REG_WOBBLE_AMPLITUDE = 4'd6,
    REG_SHAPE_MODE       = 4'd7
  } reg_index_t;

  // Shape modes; anything else is the solid tube
  localparam logic [2:0] MODE_RIBBON       = 3'd0;
  localparam logic [2:0] MODE_DISSECT      = 3'd1;
  localparam logic [2:0] MODE_CIRC_RIBBON  = 3'd3;
  localparam logic [2:0] MODE_CIRC_DISSECT = 3'd4;

  typedef struct packed {
    logic                    neg;
    logic signed [ANG_W-1:0] ang;
  } fold_t;

  // Symmetric saturation to +-(2^31-1)
  function automatic logic signed [COORD_W-1:0] sat31(input logic signed [ANG_W-1:0] v);
    if (v > 35'sd2147483647) begin
      sat31 = 32'sh7FFFFFFF;
    end else if (v < -35'sd2147483647) begin
      sat31 = 32'sh80000001;
    end else begin
      sat31 = v[COORD_W-1:0];
    end
  endfunction

  // Angle in [0, 2pi) folded into [-pi/2, pi/2]; neg flags a sign flip of sin and cos
  function automatic fold_t fold_angle(input logic [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] t;
    t = $signed(a);
    if (t > PI_Q30) begin
      t = t - TWO_PI_Q30;
    end
    fold_angle.neg = 1'b0;
    if (t > HALF_PI_Q30) begin
      t = t - PI_Q30;
      fold_angle.neg = 1'b1;
    end else if (t < -HALF_PI_Q30) begin
      t = t + PI_Q30;
      fold_angle.neg = 1'b1;
    end
    fold_angle.ang = t;
  endfunction

endpackage

[sv/hrit_channels.sv]
// Valid/ready channel interfaces: sample point in, inside flag out, register writes.
// Depends on hrit_pkg.
interface hrit_point_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [hrit_pkg::COORD_W-1:0]   point_x;
  logic signed [hrit_pkg::COORD_W-1:0]   point_y;
  logic signed [hrit_pkg::COORD_W-1:0]   point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface hrit_result_if;
  logic valid;
  logic ready;
  logic inside_res;
  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

interface hrit_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  reg_index;
  logic [31:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

[sv/hrit_cordic_vec.sv]
// Pipelined CORDIC in vectoring mode: angle of (x, y), one micro-rotation per stage.
// Depends on hrit_pkg.
module hrit_cordic_vec #(
  parameter int SW = 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [hrit_pkg::VEC_W-1:0]    in_x,
  input  logic signed [hrit_pkg::VEC_W-1:0]    in_y,
  input  logic [SW-1:0]                        in_side,
  output logic                                 out_valid,
  output logic signed [hrit_pkg::ANG_W-1:0]    out_z,
  output logic [SW-1:0]                        out_side
);
  localparam int N = hrit_pkg::CORDIC_STEPS;

  logic signed [hrit_pkg::VEC_W-1:0] sx [N];
  logic signed [hrit_pkg::VEC_W-1:0] sy [N];
  logic signed [hrit_pkg::ANG_W-1:0] sz [N];
  logic [SW-1:0]                     ss [N];
  logic                              sv [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [hrit_pkg::ANG_W-1:0] A =
      hrit_pkg::ANG_W'(hrit_pkg::ATAN_TABLE[i]);
    logic signed [hrit_pkg::VEC_W-1:0] xi, yi;
    logic signed [hrit_pkg::ANG_W-1:0] zi;
    logic [SW-1:0]                     si;
    logic                              vi;
    if (i == 0) begin : g_head
      assign xi = in_x;
      assign yi = in_y;
      assign zi = '0;
      assign si = in_side;
      assign vi = in_valid;
    end else begin : g_tail
      assign xi = sx[i-1];
      assign yi = sy[i-1];
      assign zi = sz[i-1];
      assign si = ss[i-1];
      assign vi = sv[i-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i] <= 1'b0;
      end else if (en) begin
        sv[i] <= vi;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ss[i] <= si;
        if (yi < 0) begin
          sx[i] <= xi - (yi >>> i);
          sy[i] <= yi + (xi >>> i);
          sz[i] <= zi - A;
        end else begin
          sx[i] <= xi + (yi >>> i);
          sy[i] <= yi - (xi >>> i);
          sz[i] <= zi + A;
        end
      end
    end
  end

  assign out_valid = sv[N-1];
  assign out_z     = sz[N-1];
  assign out_side  = ss[N-1];
endmodule

[sv/hrit_cordic_rot.sv]
// Pipelined CORDIC in rotation mode: gain-compensated cos/sin of a folded angle.
// Depends on hrit_pkg.
module hrit_cordic_rot #(
  parameter int SW = 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [hrit_pkg::ANG_W-1:0]    in_z,
  input  logic [SW-1:0]                        in_side,
  output logic                                 out_valid,
  output logic signed [hrit_pkg::ROT_W-1:0]    out_cos,
  output logic signed [hrit_pkg::ROT_W-1:0]    out_sin,
  output logic [SW-1:0]                        out_side
);
  localparam int N = hrit_pkg::CORDIC_STEPS;
  localparam logic signed [hrit_pkg::ROT_W-1:0] X0 =
    hrit_pkg::ROT_W'(hrit_pkg::CORDIC_GAIN_Q30);

  logic signed [hrit_pkg::ROT_W-1:0] sx [N];
  logic signed [hrit_pkg::ROT_W-1:0] sy [N];
  logic signed [hrit_pkg::ANG_W-1:0] sz [N];
  logic [SW-1:0]                     ss [N];
  logic                              sv [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [hrit_pkg::ANG_W-1:0] A =
      hrit_pkg::ANG_W'(hrit_pkg::ATAN_TABLE[i]);
    logic signed [hrit_pkg::ROT_W-1:0] xi, yi;
    logic signed [hrit_pkg::ANG_W-1:0] zi;
    logic [SW-1:0]                     si;
    logic                              vi;
    if (i == 0) begin : g_head
      assign xi = X0;
      assign yi = '0;
      assign zi = in_z;
      assign si = in_side;
      assign vi = in_valid;
    end else begin : g_tail
      assign xi = sx[i-1];
      assign yi = sy[i-1];
      assign zi = sz[i-1];
      assign si = ss[i-1];
      assign vi = sv[i-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i] <= 1'b0;
      end else if (en) begin
        sv[i] <= vi;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ss[i] <= si;
        if (zi >= 0) begin
          sx[i] <= xi - (yi >>> i);
          sy[i] <= yi + (xi >>> i);
          sz[i] <= zi - A;
        end else begin
          sx[i] <= xi + (yi >>> i);
          sy[i] <= yi - (xi >>> i);
          sz[i] <= zi + A;
        end
      end
    end
  end

  assign out_valid = sv[N-1];
  assign out_cos   = sx[N-1];
  assign out_sin   = sy[N-1];
  assign out_side  = ss[N-1];
endmodule

[sv/hrit_isqrt.sv]
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// Depends on hrit_pkg.
module hrit_isqrt #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [63:0]   in_n,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [31:0]   out_root,
  output logic [SW-1:0] out_side
);
  localparam int N = hrit_pkg::SQRT_STEPS;

  logic [63:0]   sn [N];
  logic [63:0]   sr [N];
  logic [SW-1:0] ss [N];
  logic          sv [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic [63:0] B = 64'd1 << (62 - 2 * i);
    logic [63:0]   ni, ri, trial;
    logic [SW-1:0] si;
    logic          vi;
    if (i == 0) begin : g_head
      assign ni = in_n;
      assign ri = '0;
      assign si = in_side;
      assign vi = in_valid;
    end else begin : g_tail
      assign ni = sn[i-1];
      assign ri = sr[i-1];
      assign si = ss[i-1];
      assign vi = sv[i-1];
    end
    assign trial = ri + B;
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i] <= 1'b0;
      end else if (en) begin
        sv[i] <= vi;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ss[i] <= si;
        if (ni >= trial) begin
          sn[i] <= ni - trial;
          sr[i] <= (ri >> 1) + B;
        end else begin
          sn[i] <= ni;
          sr[i] <= ri >> 1;
        end
      end
    end
  end

  assign out_valid = sv[N-1];
  assign out_root  = sr[N-1][31:0];
  assign out_side  = ss[N-1];
endmodule

[sv/hrit_mod2pi.sv]
// Pipelined reduction of a non-negative 64-bit value modulo 2*pi (Q30),
// one conditional subtract of a shifted modulus per stage. Depends on hrit_pkg.
module hrit_mod2pi #(
  parameter int SW = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [63:0]                      in_u,
  input  logic [SW-1:0]                    in_side,
  output logic                             out_valid,
  output logic [hrit_pkg::ANG_W-1:0]       out_m,
  output logic [SW-1:0]                    out_side
);
  localparam int N = hrit_pkg::MOD_STEPS;

  logic [63:0]   su [N];
  logic [SW-1:0] ss [N];
  logic          sv [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic [63:0] T = 64'(hrit_pkg::TWO_PI_Q30) << (N - 1 - i);
    logic [63:0]   ui;
    logic [SW-1:0] si;
    logic          vi;
    if (i == 0) begin : g_head
      assign ui = in_u;
      assign si = in_side;
      assign vi = in_valid;
    end else begin : g_tail
      assign ui = su[i-1];
      assign si = ss[i-1];
      assign vi = sv[i-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i] <= 1'b0;
      end else if (en) begin
        sv[i] <= vi;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ss[i] <= si;
        su[i] <= (ui >= T) ? ui - T : ui;
      end
    end
  end

  assign out_valid = sv[N-1];
  assign out_m     = su[N-1][hrit_pkg::ANG_W-1:0];
  assign out_side  = ss[N-1];
endmodule

[sv/helix_ribbon_inside_test_core.sv]
// Twisted-ribbon phantom inside test: one Q16.16 point in, one inside flag out.
// Takes one point per cycle unless the pipe stalls.
// Depth is set by the chain vectoring CORDIC, sqrt, modulo-2pi reducer, rotation
// CORDIC and a second sqrt. The whole pipe stalls as one when the result is held.
// Reset (rst, synchronous) clears all valid bits and the configuration registers.
// Depends on hrit_pkg, hrit_channels and the four pipe modules.
module helix_ribbon_inside_test_core (
  input logic          clk,
  input logic          rst,
  hrit_point_if.sink   point,
  hrit_result_if.source result,
  hrit_cfg_if.sink     cfg
);
  localparam int CW = hrit_pkg::COORD_W;
  localparam int AW = hrit_pkg::ANG_W;

  // Sideband bundles riding along each pipe
  typedef struct packed {
    logic signed [CW-1:0] x1, y1, z1;
    logic [63:0]          rr_n;
    logic [AW-1:0]        wa;
  } vec_side_t;

  typedef struct packed {
    logic signed [CW-1:0] x1, y1, z1;
    logic [AW-1:0]        wa;
    logic signed [AW-1:0] arc_raw;
  } sq1_side_t;

  typedef struct packed {
    logic signed [CW-1:0] secx, secy;
    logic [AW-1:0]        wa;
  } mod_side_t;

  typedef struct packed {
    logic signed [CW-1:0] secx, secy;
  } rot_side_t;

  typedef struct packed {
    logic [63:0]    d1abs;
    logic signed [33:0] rad;
  } sq2_side_t;

  // ---------------- configuration registers ----------------
  logic signed [CW-1:0] center_x, center_y, center_z, twist_rate;
  logic [30:0]          tube_radius, ribbon_thickness, wobble_amplitude;
  logic [2:0]           shape_mode;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x         <= '0;
      center_y         <= '0;
      center_z         <= '0;
      twist_rate       <= '0;
      tube_radius      <= '0;
      ribbon_thickness <= '0;
      wobble_amplitude <= '0;
      shape_mode       <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        hrit_pkg::REG_CENTER_X:         center_x         <= cfg.wdata;
        hrit_pkg::REG_CENTER_Y:         center_y         <= cfg.wdata;
        hrit_pkg::REG_CENTER_Z:         center_z         <= cfg.wdata;
        hrit_pkg::REG_TWIST_RATE:       twist_rate       <= cfg.wdata;
        hrit_pkg::REG_TUBE_RADIUS:      tube_radius      <= cfg.wdata[30:0];
        hrit_pkg::REG_RIBBON_THICKNESS: ribbon_thickness <= cfg.wdata[30:0];
        hrit_pkg::REG_WOBBLE_AMPLITUDE: wobble_amplitude <= cfg.wdata[30:0];
        hrit_pkg::REG_SHAPE_MODE:       shape_mode       <= cfg.wdata[2:0];
        default: ;
      endcase
    end
  end

  // Circular centerline for modes 3 and up (5, 6, 7 act as circular solid tube)
  logic circle;
  assign circle = (shape_mode >= hrit_pkg::MODE_CIRC_RIBBON);

  // ---------------- global stall ----------------
  // Every stage moves when the result slot is empty or being taken.
  logic res_valid, adv;
  assign adv         = !res_valid || result.ready;
  assign point.ready = adv;

  // ---------------- stage A: centered, saturated coordinates ----------------
  logic                 a_v;
  logic signed [CW-1:0] a_x1, a_y1, a_z1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= point.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a_x1 <= hrit_pkg::sat31(AW'(point.point_x) - AW'(center_x));
      a_y1 <= hrit_pkg::sat31(AW'(point.point_y) - AW'(center_y));
      a_z1 <= hrit_pkg::sat31(AW'(point.point_z) - AW'(center_z));
    end
  end

  // ---------------- stage B: squares and wobble phase product ----------------
  logic                 b_v;
  logic signed [CW-1:0] b_x1, b_y1, b_z1;
  logic signed [63:0]   b_ysq, b_zsq;
  logic [53:0]          b_wprod;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (adv) begin
      b_v <= a_v;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b_x1    <= a_x1;
      b_y1    <= a_y1;
      b_z1    <= a_z1;
      b_ysq   <= a_y1 * a_y1;
      b_zsq   <= a_z1 * a_z1;
      // z1 mod period is its low bits; phase = r * 2pi / period
      b_wprod <= 54'(a_z1[hrit_pkg::WOBBLE_LOG2-1:0]) * 54'(hrit_pkg::TWO_PI_Q30);
    end
  end

  // ---------------- arc angle: vectoring CORDIC on (z1, y1) ----------------
  // For z1 < 0 both operands flip and pi is added later.
  logic                               z_pos;
  logic signed [hrit_pkg::VEC_W-1:0]  vz_ext, vy_ext, vec_x, vec_y;
  vec_side_t                          vec_in_side, vec_out_side;
  logic                               vec_v;
  logic signed [AW-1:0]               vec_z;

  assign z_pos  = (b_z1 > 0);
  assign vz_ext = z_pos ? hrit_pkg::VEC_W'(b_z1) : -hrit_pkg::VEC_W'(b_z1);
  assign vy_ext = z_pos ? hrit_pkg::VEC_W'(b_y1) : -hrit_pkg::VEC_W'(b_y1);
  assign vec_x  = vz_ext <<< hrit_pkg::VEC_PRESCALE;
  assign vec_y  = vy_ext <<< hrit_pkg::VEC_PRESCALE;

  assign vec_in_side.x1   = b_x1;
  assign vec_in_side.y1   = b_y1;
  assign vec_in_side.z1   = b_z1;
  assign vec_in_side.rr_n = $unsigned(b_ysq) + $unsigned(b_zsq);
  assign vec_in_side.wa   = AW'(b_wprod >> hrit_pkg::WOBBLE_LOG2);

  hrit_cordic_vec #(.SW($bits(vec_side_t))) u_vec (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (b_v),
    .in_x     (vec_x),
    .in_y     (vec_y),
    .in_side  (vec_in_side),
    .out_valid(vec_v),
    .out_z    (vec_z),
    .out_side (vec_out_side)
  );

  // ---------------- distance from bend center: sqrt(y1^2 + z1^2) ----------------
  sq1_side_t   sq1_in_side, sq1_out_side;
  logic        sq1_v;
  logic [31:0] sq1_root;

  assign sq1_in_side.x1      = vec_out_side.x1;
  assign sq1_in_side.y1      = vec_out_side.y1;
  assign sq1_in_side.z1      = vec_out_side.z1;
  assign sq1_in_side.wa      = vec_out_side.wa;
  assign sq1_in_side.arc_raw = vec_z;

  hrit_isqrt #(.SW($bits(sq1_side_t))) u_sqrt_bend (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (vec_v),
    .in_n     (vec_out_side.rr_n),
    .in_side  (sq1_in_side),
    .out_valid(sq1_v),
    .out_root (sq1_root),
    .out_side (sq1_out_side)
  );

  // ---------------- stage D: centerline length and section offset ----------------
  logic signed [AW-1:0] arc;
  always_comb begin
    if (sq1_out_side.z1 == 0) begin
      arc = (sq1_out_side.y1 > 0) ? hrit_pkg::HALF_PI_Q30 : -hrit_pkg::HALF_PI_Q30;
    end else if (sq1_out_side.z1 > 0) begin
      arc = sq1_out_side.arc_raw;
    end else begin
      arc = sq1_out_side.arc_raw + hrit_pkg::PI_Q30;
    end
  end

  logic                 d_v;
  logic signed [CW-1:0] d_len, d_secx, d_secy;
  logic [AW-1:0]        d_wa;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (adv) begin
      d_v <= sq1_v;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      d_secx <= sq1_out_side.x1;
      d_wa   <= sq1_out_side.wa;
      if (circle) begin
        // arc length never reaches the saturation bound
        d_len  <= CW'(arc >>> hrit_pkg::ARC_SHIFT);
        d_secy <= hrit_pkg::sat31(hrit_pkg::BEND_RADIUS - $signed(AW'(sq1_root)));
      end else begin
        d_len  <= sq1_out_side.z1;
        d_secy <= sq1_out_side.y1;
      end
    end
  end

  // ---------------- stage E: twist product ----------------
  logic                 e_v;
  logic signed [63:0]   e_prod;
  logic signed [CW-1:0] e_secx, e_secy;
  logic [AW-1:0]        e_wa;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (adv) begin
      e_v <= d_v;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      e_prod <= d_len * twist_rate;
      e_secx <= d_secx;
      e_secy <= d_secy;
      e_wa   <= d_wa;
    end
  end

  // ---------------- stage F: Q30 angle, lifted non-negative ----------------
  logic                 f_v;
  logic [63:0]          f_u;
  mod_side_t            f_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (adv) begin
      f_v <= e_v;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      f_u         <= $unsigned(e_prod >>> 2) + hrit_pkg::MOD_BIAS;
      f_side.secx <= e_secx;
      f_side.secy <= e_secy;
      f_side.wa   <= e_wa;
    end
  end

  // ---------------- twist angle modulo 2pi ----------------
  mod_side_t     mod_out_side;
  logic          mod_v;
  logic [AW-1:0] mod_m;

  hrit_mod2pi #(.SW($bits(mod_side_t))) u_mod (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (f_v),
    .in_u     (f_u),
    .in_side  (f_side),
    .out_valid(mod_v),
    .out_m    (mod_m),
    .out_side (mod_out_side)
  );

  // ---------------- stage G: fold both angles to [-pi/2, pi/2] ----------------
  hrit_pkg::fold_t fold_t_ang, fold_w_ang;
  assign fold_t_ang = hrit_pkg::fold_angle(mod_m);
  assign fold_w_ang = hrit_pkg::fold_angle(mod_out_side.wa);

  logic                 g_v;
  logic signed [AW-1:0] g_ang_t, g_ang_w;
  logic                 g_neg_w;
  rot_side_t            g_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (adv) begin
      g_v <= mod_v;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      // the twist sign flip drops out: only |d1| is used
      g_ang_t     <= fold_t_ang.ang;
      g_ang_w     <= fold_w_ang.ang;
      g_neg_w     <= fold_w_ang.neg;
      g_side.secx <= mod_out_side.secx;
      g_side.secy <= mod_out_side.secy;
    end
  end

  // ---------------- twist and wobble sin/cos, two matched CORDICs ----------------
  rot_side_t                          rot_out_side;
  logic                               rot_v, rotw_v, rotw_neg;
  logic signed [hrit_pkg::ROT_W-1:0]  rot_c, rot_s, rotw_c, rotw_s;

  hrit_cordic_rot #(.SW($bits(rot_side_t))) u_rot_twist (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (g_v),
    .in_z     (g_ang_t),
    .in_side  (g_side),
    .out_valid(rot_v),
    .out_cos  (rot_c),
    .out_sin  (rot_s),
    .out_side (rot_out_side)
  );

  hrit_cordic_rot #(.SW(1)) u_rot_wobble (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (g_v),
    .in_z     (g_ang_w),
    .in_side  (g_neg_w),
    .out_valid(rotw_v),
    .out_cos  (rotw_c),
    .out_sin  (rotw_s),
    .out_side (rotw_neg)
  );

  // ---------------- stage H: products ----------------
  logic               h_v, h_neg_w;
  logic signed [63:0] h_p1, h_p2, h_pw, h_sxx, h_syy;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v <= 1'b0;
    end else if (adv) begin
      h_v <= rot_v && rotw_v;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      h_p1    <= 64'(rot_out_side.secx) * 64'(rot_c);
      h_p2    <= 64'(rot_out_side.secy) * 64'(rot_s);
      h_pw    <= $signed(64'(wobble_amplitude)) * 64'(rotw_s);
      h_sxx   <= rot_out_side.secx * rot_out_side.secx;
      h_syy   <= rot_out_side.secy * rot_out_side.secy;
      h_neg_w <= rotw_neg;
      // wobble cosine is not needed
      if (rotw_c == '0) begin
      end
    end
  end

  // ---------------- stage I: |d1|, section radius sum, wobbled radius ----------------
  logic signed [63:0] d1_sum, wob;
  assign d1_sum = h_p1 + h_p2;
  assign wob    = h_neg_w ? -h_pw : h_pw;

  logic          i_v;
  logic [63:0]   i_sumsq;
  sq2_side_t     i_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_v <= 1'b0;
    end else if (adv) begin
      i_v <= h_v;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      i_sumsq      <= $unsigned(h_sxx) + $unsigned(h_syy);
      i_side.d1abs <= (d1_sum < 0) ? $unsigned(-d1_sum) : $unsigned(d1_sum);
      if (wobble_amplitude != '0) begin
        i_side.rad <= $signed(34'(tube_radius)) + 34'(wob >>> 30);
      end else begin
        i_side.rad <= $signed(34'(tube_radius));
      end
    end
  end

  // ---------------- distance from centerline ----------------
  sq2_side_t   sq2_out_side;
  logic        sq2_v;
  logic [31:0] d2;

  hrit_isqrt #(.SW($bits(sq2_side_t))) u_sqrt_sec (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (i_v),
    .in_n     (i_sumsq),
    .in_side  (i_side),
    .out_valid(sq2_v),
    .out_root (d2),
    .out_side (sq2_out_side)
  );

  // ---------------- final tests and result register ----------------
  logic [63:0] half_thick;
  logic        in_tube, in_slab, is_inside;

  assign half_thick = 64'(ribbon_thickness) << 29;
  assign in_tube    = (sq2_out_side.rad > 0) &&
                      ($signed(35'(d2)) < 35'(sq2_out_side.rad));
  assign in_slab    = (sq2_out_side.d1abs <= half_thick);

  always_comb begin
    case (shape_mode) inside
      hrit_pkg::MODE_RIBBON, hrit_pkg::MODE_CIRC_RIBBON:   is_inside = in_tube && in_slab;
      hrit_pkg::MODE_DISSECT, hrit_pkg::MODE_CIRC_DISSECT: is_inside = in_tube && !in_slab;
      default:                                             is_inside = in_tube;
    endcase
  end

  logic inside_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= sq2_v;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      inside_q <= is_inside;
    end
  end

  assign result.valid      = res_valid;
  assign result.inside_res = inside_q;
endmodule

[verif/helix_ribbon_inside_test_core_tb.sv]
// Testbench for helix_ribbon_inside_test_core: drives points and register writes,
// predicts every inside flag with its own fixed-point model and compares in order.
// Depends on hrit_pkg, hrit_channels and the core.
`timescale 1ns / 100ps

module helix_ribbon_inside_test_core_tb;

  localparam logic [2:0] MODE_SOLID      = 3'd2;
  localparam logic [2:0] MODE_CIRC_SOLID = 3'd5;
  localparam int         PIPE_DRAIN      = 220;
  localparam longint     BEND_Q16        = 2097152;
  localparam longint     WOBBLE_Q16      = 1048576;

  logic clk;
  logic rst;

  hrit_point_if  pt();
  hrit_result_if rs();
  hrit_cfg_if    cf();

  helix_ribbon_inside_test_core u_top (
    .clk    (clk),
    .rst    (rst),
    .point  (pt.sink),
    .result (rs.source),
    .cfg    (cf.sink)
  );

  // Shadow copy of the phantom registers, raw bit patterns
  logic [31:0] sh_cx, sh_cy, sh_cz, sh_twist;
  logic [30:0] sh_radius, sh_thick, sh_wobble;
  logic [2:0]  sh_mode;

  bit     expected_inside[$];  // flags still owed by the pipe
  int     mismatches;
  bit     no_idle;             // burst stretches: no gaps, no stalls
  longint span;                // half-width of the well-formed point cloud

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop if the pipe hangs
  initial begin
    #20ms;
    $display("helix_ribbon_inside_test_core test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------
  function automatic longint clamp31(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483647) return -64'sd2147483647;
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // angle in [0, 2pi) Q30 -> cos, sin Q30 via rotation CORDIC
  task automatic rotate_unit(input longint a, output longint c, output longint s);
    longint x, y, z, nx;
    bit     flip;
    x = longint'(hrit_pkg::CORDIC_GAIN_Q30);
    y = 0;
    flip = 1'b0;
    if (a > longint'(hrit_pkg::PI_Q30)) a -= longint'(hrit_pkg::TWO_PI_Q30);
    if (a > longint'(hrit_pkg::HALF_PI_Q30)) begin
      a -= longint'(hrit_pkg::PI_Q30);
      flip = 1'b1;
    end else if (a < -longint'(hrit_pkg::HALF_PI_Q30)) begin
      a += longint'(hrit_pkg::PI_Q30);
      flip = 1'b1;
    end
    z = a;
    for (int i = 0; i < hrit_pkg::CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(hrit_pkg::ATAN_TABLE[i]);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += longint'(hrit_pkg::ATAN_TABLE[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // atan(num/den), den > 0, vectoring CORDIC on operands scaled by 2^24
  function automatic longint arc_atan(longint num, longint den);
    longint x, y, z, nx;
    x = den * 64'sd16777216;
    y = num * 64'sd16777216;
    z = 0;
    for (int i = 0; i < hrit_pkg::CORDIC_STEPS; i++) begin
      if (y < 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(hrit_pkg::ATAN_TABLE[i]);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += longint'(hrit_pkg::ATAN_TABLE[i]);
      end
      x = nx;
    end
    return z;
  endfunction

  // length times twist rate, reduced into [0, 2pi) Q30
  function automatic longint ribbon_phase(longint len);
    longint m;
    m = ((len * longint'($signed(sh_twist))) >>> 2) % longint'(hrit_pkg::TWO_PI_Q30);
    if (m < 0) m += longint'(hrit_pkg::TWO_PI_Q30);
    return m;
  endfunction

  task automatic predict_inside(input logic [31:0] px, py, pz, output bit is_inside);
    longint x1, y1, z1, secx, secy, ang, c, s, d1, rad, half, arc, r, wc, ws;
    longint unsigned d2, rr;
    bit circle, in_tube, in_slab;
    logic [2:0] sub;
    x1 = clamp31(longint'($signed(px)) - longint'($signed(sh_cx)));
    y1 = clamp31(longint'($signed(py)) - longint'($signed(sh_cy)));
    z1 = clamp31(longint'($signed(pz)) - longint'($signed(sh_cz)));
    circle = sh_mode >= hrit_pkg::MODE_CIRC_RIBBON;
    if (!circle) sub = sh_mode;
    else if (sh_mode >= MODE_CIRC_SOLID) sub = MODE_SOLID;
    else sub = sh_mode - hrit_pkg::MODE_CIRC_RIBBON;
    secx = x1;
    secy = y1;
    if (!circle) begin
      ang = ribbon_phase(z1);
    end else begin
      // straight up or down the y axis: quarter turn either way
      if (z1 == 0) begin
        arc = (y1 > 0) ? longint'(hrit_pkg::HALF_PI_Q30) : -longint'(hrit_pkg::HALF_PI_Q30);
      end else if (z1 > 0) begin
        arc = arc_atan(y1, z1);
      end else begin
        arc = arc_atan(-y1, -z1) + longint'(hrit_pkg::PI_Q30);
      end
      ang = ribbon_phase(clamp31(((arc >>> 2) * BEND_Q16) >>> 28));
      rr = floor_sqrt(longint'(y1 * y1) + longint'(z1 * z1));
      secy = clamp31(BEND_Q16 - longint'(rr));
    end
    rotate_unit(ang, c, s);
    d1 = secx * c + secy * s;
    if (d1 < 0) d1 = -d1;
    d2 = floor_sqrt(longint'(secx * secx) + longint'(secy * secy));
    rad = longint'(sh_radius);
    if (sh_wobble != 0) begin
      r = z1 % WOBBLE_Q16;
      if (r < 0) r += WOBBLE_Q16;
      rotate_unit((r * longint'(hrit_pkg::TWO_PI_Q30)) / WOBBLE_Q16, wc, ws);
      rad += (longint'(sh_wobble) * ws) >>> 30;
    end
    half = longint'(sh_thick) * 64'sd536870912;
    in_tube = rad > 0 && longint'(d2) < rad;
    in_slab = d1 <= half;
    if (sub == hrit_pkg::MODE_DISSECT) is_inside = in_tube && !in_slab;
    else if (sub == MODE_SOLID) is_inside = in_tube;
    else is_inside = in_tube && in_slab;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls on ready, in-order comparison
  // ---------------------------------------------------------------------------
  initial begin
    int  stall;
    bit  want;
    stall = 0;
    rs.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rs.valid && rs.ready) begin
        if (expected_inside.size() == 0) begin
          $display("%0t: unexpected result transfer, inside_res=%0b", $time, rs.inside_res);
          mismatches++;
        end else begin
          want = expected_inside.pop_front();
          if (rs.inside_res !== want) begin
            $display("%0t: inside_res mismatch, expected %0b actual %0b",
                     $time, want, rs.inside_res);
            mismatches++;
          end
        end
      end
      if (rst || no_idle) begin
        rs.ready <= !rst;
        stall = 0;
      end else if (stall > 0) begin
        rs.ready <= 1'b0;
        stall--;
      end else begin
        rs.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // mostly short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_point(input logic [31:0] px, py, pz);
    bit flag;
    int gap;
    pt.valid   <= 1'b1;
    pt.point_x <= px;
    pt.point_y <= py;
    pt.point_z <= pz;
    do @(posedge clk); while (!pt.ready);
    predict_inside(px, py, pz, flag);
    expected_inside.push_back(flag);
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      pt.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain the pipe before any register transfer
  task automatic wait_idle();
    if (pt.valid) begin
      pt.valid <= 1'b0;
      @(posedge clk);
    end
    while (expected_inside.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // leaves valid high; the caller drops it after the last write
  task automatic write_reg(input hrit_pkg::reg_index_t idx, input logic [31:0] data);
    cf.valid     <= 1'b1;
    cf.reg_index <= idx;
    cf.wdata     <= data;
    do @(posedge clk); while (!cf.ready);
    case (idx)
      hrit_pkg::REG_CENTER_X:         sh_cx     = data;
      hrit_pkg::REG_CENTER_Y:         sh_cy     = data;
      hrit_pkg::REG_CENTER_Z:         sh_cz     = data;
      hrit_pkg::REG_TWIST_RATE:       sh_twist  = data;
      hrit_pkg::REG_TUBE_RADIUS:      sh_radius = data[30:0];
      hrit_pkg::REG_RIBBON_THICKNESS: sh_thick  = data[30:0];
      hrit_pkg::REG_WOBBLE_AMPLITUDE: sh_wobble = data[30:0];
      hrit_pkg::REG_SHAPE_MODE:       sh_mode   = data[2:0];
      default: ;
    endcase
  endtask

  task automatic load_phantom(input logic [31:0] cx, cy, cz, twist, radius, thick, wobble,
                              input logic [2:0] mode);
    wait_idle();
    write_reg(hrit_pkg::REG_CENTER_X, cx);
    write_reg(hrit_pkg::REG_CENTER_Y, cy);
    write_reg(hrit_pkg::REG_CENTER_Z, cz);
    write_reg(hrit_pkg::REG_TWIST_RATE, twist);
    write_reg(hrit_pkg::REG_TUBE_RADIUS, radius);
    write_reg(hrit_pkg::REG_RIBBON_THICKNESS, thick);
    write_reg(hrit_pkg::REG_WOBBLE_AMPLITUDE, wobble);
    write_reg(hrit_pkg::REG_SHAPE_MODE, {29'd0, mode});
    cf.valid <= 1'b0;
  endtask

  function automatic logic [31:0] near(logic [31:0] base, longint half_width);
    return base + 32'($urandom_range(0, 32'(2 * half_width))) - 32'(half_width);
  endfunction

  // Mostly points in and around the shape; some full-range noise
  task automatic random_points(input int n);
    logic [31:0] px, py, pz;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 85) begin
        px = near(sh_cx, span);
        if (sh_mode >= hrit_pkg::MODE_CIRC_RIBBON) begin
          py = near(sh_cy, BEND_Q16 + span);
          pz = near(sh_cz, BEND_Q16 + span);
        end else begin
          py = near(sh_cy, span);
          pz = near(sh_cz, 4 * WOBBLE_Q16);
        end
      end else begin
        px = $urandom;
        py = $urandom;
        pz = $urandom;
      end
      send_point(px, py, pz);
    end
    no_idle = 1'b0;
  endtask

  // Saturating and zero-offset corners relative to the current center
  task automatic corner_points();
    send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_point(32'h80000000, 32'h80000000, 32'h80000000);
    send_point(32'h80000000, 32'h7FFFFFFF, 32'h00000000);
    send_point(sh_cx, sh_cy, sh_cz);
    send_point(sh_cx, sh_cy + 32'h00010000, sh_cz);       // z offset zero, y above
    send_point(sh_cx, sh_cy - 32'h00010000, sh_cz);       // z offset zero, y below
    send_point(sh_cx + 32'h00008000, sh_cy, sh_cz - 32'h00200000);  // behind the center
    send_point(sh_cx, sh_cy + 32'h00200000, sh_cz + 32'h00000001);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_state();
    // all registers zero: radius zero, nothing is inside
    span = 64'sd1 << 20;
    corner_points();
    random_points(20);
  endtask

  task automatic test_straight_shapes();
    for (int m = 0; m <= int'(MODE_SOLID); m++) begin
      load_phantom($urandom, $urandom, $urandom, 32'sd13107, 32'h0008_0000,
                   32'h0002_0000, 32'd0, 3'(m));
      span = 64'sd12 << 16;
      corner_points();
      random_points(150);
    end
  endtask

  task automatic test_bent_shapes();
    for (int m = int'(hrit_pkg::MODE_CIRC_RIBBON); m <= 7; m++) begin
      load_phantom($urandom, $urandom, $urandom, -32'sd26214, 32'h0006_0000,
                   32'h0001_8000, 32'd0, 3'(m));
      span = 64'sd10 << 16;
      corner_points();
      random_points(m < 6 ? 130 : 60);
    end
  endtask

  task automatic test_wobble();
    // amplitude above the radius drives the radius negative over part of a period
    load_phantom(32'd0, 32'd0, 32'd0, 32'sd65536, 32'h0004_0000, 32'h0001_0000,
                 32'h0006_0000, MODE_SOLID);
    span = 64'sd12 << 16;
    corner_points();
    random_points(150);
    load_phantom($urandom, $urandom, $urandom, 32'sd40000, 32'h0008_0000,
                 32'h0003_0000, 32'h0002_0000, hrit_pkg::MODE_CIRC_DISSECT);
    span = 64'sd12 << 16;
    random_points(150);
  endtask

  task automatic test_register_extremes();
    load_phantom(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                 32'h7FFFFFFF, 32'h7FFFFFFF, hrit_pkg::MODE_RIBBON);
    span = 64'sd1 << 30;
    corner_points();
    random_points(60);
    load_phantom(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                 32'd0, 32'd1, hrit_pkg::MODE_CIRC_DISSECT);
    corner_points();
    random_points(60);
    // random register contents; wobble amplitude random on odd passes, zero on even ones
    for (int k = 0; k < 4; k++) begin
      load_phantom($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   (k % 2) ? $urandom : 32'd0, 3'($urandom_range(0, 7)));
      span = 64'sd1 << $urandom_range(18, 28);
      random_points(40);
    end
  endtask

  initial begin
    mismatches = 0;
    no_idle    = 1'b0;
    sh_cx = '0; sh_cy = '0; sh_cz = '0; sh_twist = '0;
    sh_radius = '0; sh_thick = '0; sh_wobble = '0; sh_mode = '0;
    rst          <= 1'b1;
    pt.valid     <= 1'b0;
    pt.point_x   <= '0;
    pt.point_y   <= '0;
    pt.point_z   <= '0;
    cf.valid     <= 1'b0;
    cf.reg_index <= hrit_pkg::REG_CENTER_X;
    cf.wdata     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_straight_shapes();
    test_bent_shapes();
    test_wobble();
    test_register_extremes();

    wait_idle();
    if (mismatches == 0) begin
      $display("helix_ribbon_inside_test_core test passed");
    end else begin
      $display("helix_ribbon_inside_test_core test failed");
    end
    $finish;
  end

endmodule
